[rtl/vrt_pkg.sv]
// Shared types, widths, codes and helpers for the voxel ray traversal unit.
// No dependencies; imported by every module of the block.
package vrt_pkg;

  // Parameter defaults.
  localparam int GRID_SIDE_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int MAX_STEPS_DEF = 64;

  // Fixed field widths.
  localparam int COORD_W = 16;
  localparam int CELL_W  = 4;
  localparam int MAG_W   = 16;
  localparam int NUM_W   = 17;
  localparam int PROD_W  = NUM_W + MAG_W;
  localparam int VOX_W   = 18;
  localparam int VOXO_W  = 8;
  localparam int NPAIR   = 6;

  // Stream word widths and field offsets.
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 80;
  localparam int OFS_CX     = 0;
  localparam int OFS_CY     = 4;
  localparam int OFS_CZ     = 8;
  localparam int OFS_VIS    = 12;
  localparam int OFS_START  = 13;
  localparam int OFS_END    = 61;

  // Axis codes for the stepped axis, and normal codes.
  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_Z    = 2'd2;
  localparam logic [1:0] AX_NONE = 2'd3;
  localparam logic [1:0] NRM_NONE = 2'd0;
  localparam logic [1:0] NRM_X    = 2'd1;
  localparam logic [1:0] NRM_Y    = 2'd2;
  localparam logic [1:0] NRM_Z    = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mem_wr;
    logic       clr_en;
    logic       prod_en;
    logic [2:0] prod_idx;
    logic       walk_en;
    logic       hp_mul;
    logic       div_en;
    logic       hp_store;
    logic [1:0] hp_idx;
    logic       res_load;
    logic       res_hit;
  } vrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_mode;
    logic clr_last;
    logic cell_ok;
    logic vis;
    logic ws_stop;
    logic hp_need;
    logic out_busy;
  } vrt_sts_t;

  // Index of the cross product num[a] * mag[b] among the six ordered pairs.
  function automatic logic [2:0] pair_idx(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] r;
    unique case ({a, b})
      {AX_X, AX_Y}: r = 3'd0;
      {AX_X, AX_Z}: r = 3'd1;
      {AX_Y, AX_X}: r = 3'd2;
      {AX_Y, AX_Z}: r = 3'd3;
      {AX_Z, AX_X}: r = 3'd4;
      {AX_Z, AX_Y}: r = 3'd5;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  // First axis (the num side) of a pair.
  function automatic logic [1:0] pair_a(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0, 3'd1: r = AX_X;
      3'd2, 3'd3: r = AX_Y;
      default:    r = AX_Z;
    endcase
    return r;
  endfunction

  // Second axis (the mag side) of a pair.
  function automatic logic [1:0] pair_b(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd2, 3'd4: r = AX_X;
      3'd0, 3'd5: r = AX_Y;
      default:    r = AX_Z;
    endcase
    return r;
  endfunction

endpackage

[rtl/vrt_ctrl.sv]
// Controller state machine of the voxel ray traversal unit.
// Depends on vrt_pkg; drives the datapath through vrt_cmd_t.
module vrt_ctrl
  import vrt_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  vrt_sts_t sts,
  output vrt_cmd_t cmd
);

  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int DW = $clog2(PROD_W);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WR   = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_WALK = 4'd4;
  localparam logic [3:0] S_HPM  = 4'd5;
  localparam logic [3:0] S_HPD  = 4'd6;
  localparam logic [3:0] S_HPS  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [SW-1:0] stp_r, stp_nxt;
  logic [DW-1:0] dcnt_r, dcnt_nxt;
  logic [1:0]    hpi_r, hpi_nxt;
  logic          hit_r, hit_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    stp_nxt   = stp_r;
    dcnt_nxt  = dcnt_r;
    hpi_nxt   = hpi_r;
    hit_nxt   = hit_r;
    cmd       = '0;
    cmd.prod_idx = idx_r;
    cmd.hp_idx   = hpi_r;
    cmd.res_hit  = hit_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          idx_nxt  = '0;
          state_nxt = (sts.in_mode == MODE_CAST) ? S_INIT : S_WR;
        end
      end
      S_WR: begin
        cmd.mem_wr = sts.cell_ok;
        state_nxt  = S_IDLE;
      end
      S_INIT: begin
        cmd.prod_en = 1'b1;
        if (idx_r == 3'(NPAIR - 1)) begin
          stp_nxt   = '0;
          state_nxt = S_WALK;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      S_WALK: begin
        if (sts.vis) begin
          hit_nxt   = 1'b1;
          hpi_nxt   = AX_X;
          state_nxt = S_HPM;
        end else if (stp_r == SW'(MAX_STEPS)) begin
          hit_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          cmd.walk_en = 1'b1;
          if (sts.ws_stop) begin
            hit_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            stp_nxt = stp_r + SW'(1);
          end
        end
      end
      S_HPM: begin
        if (sts.hp_need) begin
          cmd.hp_mul = 1'b1;
          dcnt_nxt   = '0;
          state_nxt  = S_HPD;
        end else begin
          cmd.hp_store = 1'b1;
          if (hpi_r == AX_Z) begin
            state_nxt = S_FIN;
          end else begin
            hpi_nxt = hpi_r + 2'd1;
          end
        end
      end
      S_HPD: begin
        cmd.div_en = 1'b1;
        dcnt_nxt   = dcnt_r + DW'(1);
        if (dcnt_r == DW'(PROD_W - 1)) begin
          state_nxt = S_HPS;
        end
      end
      S_HPS: begin
        cmd.hp_store = 1'b1;
        if (hpi_r == AX_Z) begin
          state_nxt = S_FIN;
        end else begin
          hpi_nxt   = hpi_r + 2'd1;
          state_nxt = S_HPM;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
      stp_r   <= '0;
      dcnt_r  <= '0;
      hpi_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      stp_r   <= stp_nxt;
      dcnt_r  <= dcnt_nxt;
      hpi_r   <= hpi_nxt;
      hit_r   <= hit_nxt;
    end
  end

endmodule

[rtl/vrt_dpath.sv]
// Datapath of the voxel ray traversal unit: occupancy memory, walk registers,
// shared multiplier, serial divider and result register. Depends on vrt_pkg.
module vrt_dpath
  import vrt_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vrt_cmd_t              cmd,
  output vrt_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int IDX_W  = $clog2(GRID_SIDE);
  localparam int ADDR_W = 3 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam logic [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_BITS;

  // Occupancy memory and its ports.
  logic              mem [DEPTH];
  logic [ADDR_W-1:0] clr_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              rd_r, ing_r, ing;

  // Captured write item.
  logic [CELL_W-1:0] cx_r, cy_r, cz_r;
  logic              cvis_r;

  // Per-axis walk state.
  logic signed [COORD_W-1:0] s_r   [3];
  logic                      neg_r [3];
  logic [MAG_W-1:0]          mag_r [3];
  logic [NUM_W-1:0]          num_r [3];
  logic signed [VOX_W-1:0]   vox_r [3];
  logic signed [VOX_W-1:0]   vox_nxt [3];
  logic [PROD_W-1:0]         p_r   [NPAIR];
  logic                      magz  [3];
  logic                      up    [3];
  logic [NUM_W-1:0]          tn_r;
  logic [1:0]                hax_r, hax_i, last_r, ax;
  logic signed [COORD_W-1:0] pt_r  [3];

  // Load-time decode of the cast fields.
  logic signed [COORD_W-1:0] ld_s [3];
  logic signed [COORD_W-1:0] ld_e [3];
  logic signed [COORD_W:0]   ld_d [3];
  logic signed [COORD_W:0]   ld_nd [3];
  logic [NUM_W-1:0]          ld_frac [3];
  logic signed [VOX_W-1:0]   ld_sx [3];

  // Multiplier and divider.
  logic [NUM_W-1:0]  ma;
  logic [MAG_W-1:0]  mb;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] quo_r;
  logic [MAG_W-1:0]  rem_r;
  logic [MAG_W:0]    trial;
  logic [MAG_W-1:0]  dvs;
  logic              ge;

  // Walk decisions.
  logic e01, e02, e12, ws_stop, adv;
  logic [COORD_W-1:0] hp_q;
  logic               hp_need;

  // Result register.
  logic                     ov_r, oh_r, on_r;
  logic [1:0]               onax_r;
  logic [VOXO_W-1:0]        ovx_r [3];
  logic [COORD_W-1:0]       opt_r [3];
  logic                     nrm_neg;
  logic [IDX_W-1:0]         wx, wy, wz, rx, ry, rz;

  // Field decode per axis.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ld_s[i]    = in_tdata[OFS_START + COORD_W * i +: COORD_W];
      ld_e[i]    = in_tdata[OFS_END + COORD_W * i +: COORD_W];
      ld_d[i]    = (COORD_W + 1)'(ld_e[i]) - (COORD_W + 1)'(ld_s[i]);
      ld_nd[i]   = -ld_d[i];
      ld_frac[i] = NUM_W'(ld_s[i][FRAC_BITS-1:0]);
      ld_sx[i]   = VOX_W'(ld_s[i]) >>> FRAC_BITS;
      magz[i]    = (mag_r[i] == '0);
      up[i]      = !neg_r[i] && !magz[i];
    end
  end

  // Next crossing comparison, ties to the later axis.
  always_comb begin
    e01 = magz[0] ? 1'b0 : (magz[1] ? 1'b1 :
          (p_r[pair_idx(AX_X, AX_Y)] < p_r[pair_idx(AX_Y, AX_X)]));
    e02 = magz[0] ? 1'b0 : (magz[2] ? 1'b1 :
          (p_r[pair_idx(AX_X, AX_Z)] < p_r[pair_idx(AX_Z, AX_X)]));
    e12 = magz[1] ? 1'b0 : (magz[2] ? 1'b1 :
          (p_r[pair_idx(AX_Y, AX_Z)] < p_r[pair_idx(AX_Z, AX_Y)]));
    if (e01) begin
      ax = e02 ? AX_X : AX_Z;
    end else begin
      ax = e12 ? AX_Y : AX_Z;
    end
    ws_stop = magz[ax] || (num_r[ax] > NUM_W'(mag_r[ax]));
    adv     = cmd.walk_en && !ws_stop;
  end

  // Voxel after this cycle's step, used as the read address.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (adv && (ax == 2'(i))) begin
        vox_nxt[i] = up[i] ? vox_r[i] + VOX_W'(1) : vox_r[i] - VOX_W'(1);
      end else begin
        vox_nxt[i] = vox_r[i];
      end
    end
    ing = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (int'(vox_nxt[i]) < 0 || int'(vox_nxt[i]) >= GRID_SIDE) begin
        ing = 1'b0;
      end
    end
    rx = IDX_W'(vox_nxt[0]);
    ry = IDX_W'(vox_nxt[1]);
    rz = IDX_W'(vox_nxt[2]);
    wx = IDX_W'(cx_r);
    wy = IDX_W'(cy_r);
    wz = IDX_W'(cz_r);
    rd_addr = {rz, ry, rx};
    wr_addr = {wz, wy, wx};
  end

  // Occupancy memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_r] <= 1'b0;
    end else if (cmd.mem_wr) begin
      mem[wr_addr] <= cvis_r;
    end
    rd_r  <= mem[rd_addr];
    ing_r <= ing;
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_r <= clr_r + ADDR_W'(1);
    end
  end

  // Shared multiplier operands.
  always_comb begin
    if (cmd.prod_en) begin
      ma = num_r[pair_a(cmd.prod_idx)];
      mb = mag_r[pair_b(cmd.prod_idx)];
    end else begin
      ma = tn_r;
      mb = mag_r[cmd.hp_idx];
    end
    mul_p = PROD_W'(ma) * PROD_W'(mb);
  end

  // Divider step and hit point selection.
  always_comb begin
    hax_i   = (hax_r == AX_NONE) ? AX_X : hax_r;
    dvs     = mag_r[hax_i];
    trial   = {rem_r, quo_r[PROD_W-1]};
    ge      = (trial >= {1'b0, dvs});
    hp_need = (hax_r != AX_NONE) && (cmd.hp_idx != hax_r) && !magz[cmd.hp_idx];
    if (hax_r == cmd.hp_idx) begin
      hp_q = tn_r[COORD_W-1:0];
    end else if (hp_need) begin
      hp_q = quo_r[COORD_W-1:0];
    end else begin
      hp_q = '0;
    end
  end

  // Walk and hit point registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r   <= in_tdata[OFS_CX +: CELL_W];
      cy_r   <= in_tdata[OFS_CY +: CELL_W];
      cz_r   <= in_tdata[OFS_CZ +: CELL_W];
      cvis_r <= in_tdata[OFS_VIS];
      hax_r  <= AX_NONE;
      for (int i = 0; i < 3; i++) begin
        s_r[i]   <= ld_s[i];
        neg_r[i] <= ld_d[i][COORD_W];
        mag_r[i] <= ld_d[i][COORD_W] ? ld_nd[i][MAG_W-1:0] : ld_d[i][MAG_W-1:0];
        num_r[i] <= (!ld_d[i][COORD_W] && ld_d[i] != '0) ? ONE - ld_frac[i] : ld_frac[i];
        vox_r[i] <= ld_sx[i];
      end
    end
    if (cmd.prod_en) begin
      p_r[cmd.prod_idx] <= mul_p;
    end
    if (adv) begin
      tn_r      <= num_r[ax];
      hax_r     <= ax;
      num_r[ax] <= num_r[ax] + ONE;
      for (int i = 0; i < 3; i++) begin
        vox_r[i] <= vox_nxt[i];
      end
      for (int k = 0; k < NPAIR; k++) begin
        if (pair_a(3'(k)) == ax) begin
          p_r[k] <= p_r[k] + (PROD_W'(mag_r[pair_b(3'(k))]) << FRAC_BITS);
        end
      end
    end
    if (cmd.hp_mul) begin
      quo_r <= mul_p;
      rem_r <= '0;
    end else if (cmd.div_en) begin
      quo_r <= {quo_r[PROD_W-2:0], ge};
      rem_r <= ge ? MAG_W'(trial - {1'b0, dvs}) : trial[MAG_W-1:0];
    end
    if (cmd.hp_store) begin
      pt_r[cmd.hp_idx] <= neg_r[cmd.hp_idx] ? s_r[cmd.hp_idx] - $signed(hp_q)
                                            : s_r[cmd.hp_idx] + $signed(hp_q);
    end
  end

  // Last chosen axis, the normal of the result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_r <= NRM_NONE;
    end else if (cmd.walk_en && !magz[ax]) begin
      last_r <= ax + 2'd1;
    end
  end

  always_comb begin
    case (last_r)
      NRM_X:   nrm_neg = up[0];
      NRM_Y:   nrm_neg = up[1];
      NRM_Z:   nrm_neg = up[2];
      default: nrm_neg = 1'b0;
    endcase
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      oh_r   <= cmd.res_hit;
      onax_r <= last_r;
      on_r   <= nrm_neg;
      for (int i = 0; i < 3; i++) begin
        ovx_r[i] <= cmd.res_hit ? vox_r[i][VOXO_W-1:0] : '0;
        opt_r[i] <= cmd.res_hit ? pt_r[i] : '0;
      end
    end
  end

  // Result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.res_load) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = oh_r;
  assign out_tdata  = {5'b0, opt_r[2], opt_r[1], opt_r[0], on_r, onax_r,
                       ovx_r[2], ovx_r[1], ovx_r[0]};

  // Status to the controller.
  always_comb begin
    sts.in_mode  = in_tuser;
    sts.clr_last = (clr_r == '1);
    sts.cell_ok  = (int'(cx_r) < GRID_SIDE) && (int'(cy_r) < GRID_SIDE) &&
                   (int'(cz_r) < GRID_SIDE);
    sts.vis      = rd_r && ing_r;
    sts.ws_stop  = ws_stop;
    sts.hp_need  = hp_need;
    sts.out_busy = ov_r && !out_tready;
  end

endmodule

[rtl/voxel_ray_traversal_unit.sv]
// Voxel ray traversal unit: 3-D DDA walk over a one-bit occupancy grid.
// One item at a time. A cast makes one occupancy read per voxel step and,
// on a hit, uses the serial divider to find the hit point.
// Reset is synchronous, active low; afterwards a clearing pass over all
// 2^(3*ceil(log2 GRID_SIDE)) cells (4096 by default) zeroes the grid.
module voxel_ray_traversal_unit
  import vrt_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cell_x, cell_y, cell_z, cell_visible, start_x/y/z, end_x/y/z, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // voxel_x/y/z, normal_axis, normal_negative, hit_x/y/z, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // hit
  output logic                  out_tuser
);

  vrt_cmd_t cmd;
  vrt_sts_t sts;

  // Sequencer.
  vrt_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Grid, walk arithmetic and result register.
  vrt_dpath #(
    .GRID_SIDE (GRID_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/vrt_checker.sv]
// Port-level checks for the voxel ray traversal unit, bound to its top level.
// Depends on vrt_pkg for the stream widths.
module vrt_checker
  import vrt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An accepted request keeps the unit busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // A miss carries no voxel and no hit point.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[23:0] == 24'd0 && out_tdata[74:27] == 48'd0)
    else $error("miss with voxel or hit point");

  // A negative normal needs a normal axis.
  a_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> out_tdata[25:24] != NRM_NONE)
    else $error("negative normal without axis");

endmodule

bind voxel_ray_traversal_unit vrt_checker u_vrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[tb/tb_voxel_ray_traversal_unit.sv]
// Self-checking testbench for the voxel ray traversal unit: occupancy writes and ray casts
// are predicted by a DDA walk in SystemVerilog and compared with every result request.
// Depends on vrt_pkg and voxel_ray_traversal_unit.
module tb_voxel_ray_traversal_unit;
  import vrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = 16;
  localparam int FRAC = 8;
  localparam int STEPS_MAX = 64;
  localparam longint UNIT = 64'd1 << FRAC;

  typedef struct packed {
    logic              hit;
    logic signed [7:0] vx, vy, vz;
    logic [1:0]        naxis;
    logic              nneg;
    logic signed [15:0] px, py, pz;
  } cast_result_t;

  // Scoreboard: keeps its own occupancy grid and predicts each cast.
  class traversal_scoreboard;
    bit grid [SIDE*SIDE*SIDE];
    cast_result_t pending_hits[$];
    int mismatches;

    function bit occupied(int x, int y, int z);
      if (x < 0 || y < 0 || z < 0 || x >= SIDE || y >= SIDE || z >= SIDE) return 0;
      return grid[x + SIDE * (y + SIDE * z)];
    endfunction

    // True when axis a crosses its next boundary strictly before axis b.
    function bit crosses_first(longint num[3], longint mag[3], int a, int b);
      if (mag[a] == 0) return 0;
      if (mag[b] == 0) return 1;
      return num[a] * mag[b] < num[b] * mag[a];
    endfunction

    function void note_request(logic mode, logic [IN_DATA_W-1:0] d);
      int s[3], dl[3], vox[3], dir[3], pt[3];
      longint mag[3], num[3], tn, q;
      int axis, last_axis, biased;
      bit found;
      cast_result_t r;
      if (mode == MODE_WRITE) begin
        grid[d[OFS_CX+:4] + SIDE * (d[OFS_CY+:4] + SIDE * d[OFS_CZ+:4])] = d[OFS_VIS];
        return;
      end
      last_axis = -1;
      found = 0;
      for (int i = 0; i < 3; i++) begin
        s[i] = $signed(d[OFS_START + 16*i +: 16]);
        dl[i] = int'($signed(d[OFS_END + 16*i +: 16])) - s[i];
        biased = s[i] + 65536;
        vox[i] = (biased >>> FRAC) - (65536 >>> FRAC);
        dir[i] = dl[i] > 0 ? 1 : (dl[i] < 0 ? -1 : 0);
        mag[i] = dl[i] < 0 ? -dl[i] : dl[i];
        num[i] = dir[i] > 0 ? UNIT - (biased & (UNIT - 1)) : (biased & (UNIT - 1));
        pt[i] = s[i];
      end
      if (occupied(vox[0], vox[1], vox[2])) found = 1;
      else begin
        for (int n = 0; n < STEPS_MAX; n++) begin
          if (crosses_first(num, mag, 0, 1)) axis = crosses_first(num, mag, 0, 2) ? 0 : 2;
          else axis = crosses_first(num, mag, 1, 2) ? 1 : 2;
          if (mag[axis] == 0) break;
          last_axis = axis;
          tn = num[axis];
          if (tn > mag[axis]) break;
          vox[axis] += dir[axis];
          num[axis] += UNIT;
          if (occupied(vox[0], vox[1], vox[2])) begin
            found = 1;
            for (int i = 0; i < 3; i++) begin
              if (i == axis) q = tn;
              else if (mag[i] == 0) q = 0;
              else q = (mag[i] * tn) / mag[axis];
              pt[i] = s[i] + dir[i] * int'(q);
            end
            break;
          end
        end
      end
      r = '0;
      r.hit = found;
      if (found) begin
        r.vx = vox[0][7:0]; r.vy = vox[1][7:0]; r.vz = vox[2][7:0];
        r.px = pt[0][15:0]; r.py = pt[1][15:0]; r.pz = pt[2][15:0];
      end
      if (last_axis >= 0) begin
        r.naxis = 2'(last_axis + 1);
        r.nneg = dir[last_axis] > 0;
      end
      pending_hits.push_back(r);
    endfunction

    function void check_result(logic hitflag, logic [OUT_DATA_W-1:0] d);
      cast_result_t got, exp_r;
      got.hit = hitflag;
      {got.pz, got.py, got.px, got.nneg, got.naxis, got.vz, got.vy, got.vx} = d[74:0];
      if (d[79:75] != 0) got.hit = ~hitflag; // force a mismatch on nonzero padding
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending_hits.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  bit calm;
  traversal_scoreboard sb;

  voxel_ray_traversal_unit DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stall, check on each accepted request.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    out_tready <= calm || ($urandom_range(99) >= 19);
  end

  // Sends one request, with a possible idle gap first. Valid stays up after the
  // handshake until the next request or idle cycle replaces it.
  task automatic send_request(logic mode, logic [IN_DATA_W-1:0] d);
    while (!calm && $urandom_range(99) < 19) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_request(mode, d);
  endtask

  task automatic write_cell(int x, int y, int z, bit v);
    logic [IN_DATA_W-1:0] d;
    d = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
    d[IN_DATA_W-1:109] = 0;
    d[OFS_CX+:4] = 4'(x); d[OFS_CY+:4] = 4'(y); d[OFS_CZ+:4] = 4'(z); d[OFS_VIS] = v;
    send_request(MODE_WRITE, d);
  endtask

  task automatic cast_ray(int sx, int sy, int sz, int ex, int ey, int ez);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[OFS_CX+:13] = 13'($urandom);
    d[OFS_START+:48] = {16'(sz), 16'(sy), 16'(sx)};
    d[OFS_END+:48] = {16'(ez), 16'(ey), 16'(ex)};
    send_request(MODE_CAST, d);
  endtask

  // Position in or near the grid, Q8.8.
  function automatic int near_pos();
    return $urandom_range(99) < 80 ? int'($urandom_range(4095)) : int'($urandom_range(6143)) - 1024;
  endfunction

  initial begin
    int n;
    sb = new();
    rst_n = 0; in_tvalid = 0; in_tuser = 0; in_tdata = '0; out_tready = 0; calm = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // Directed: empty grid, extremes, start visible, ties, writes outside range bits.
    cast_ray(-32768, -32768, -32768, 32767, 32767, 32767);
    cast_ray(100, 100, 100, 100, 100, 100);
    write_cell(1, 1, 1, 1);
    write_cell(15, 15, 15, 1);
    write_cell(0, 0, 0, 1);
    cast_ray(300, 300, 300, 300, 300, 300);          // start voxel visible
    cast_ray(128, 128, 128, 600, 600, 600);          // three-way tie
    cast_ray(128, 300, 300, 600, 300, 300);          // x only
    cast_ray(300, 128, 300, 300, 600, 300);          // y only
    cast_ray(300, 300, 128, 300, 300, 600);          // z only
    cast_ray(800, 800, 800, 200, 200, 200);          // negative direction
    cast_ray(3800, 3800, 3800, 4095, 4095, 4095);    // far corner
    cast_ray(32767, 32767, 32767, -32768, -32768, -32768); // step cap
    cast_ray(-300, 128, 128, 600, 128, 128);         // enters grid from outside
    cast_ray(128, 128, 128, 255, 255, 255);          // ends before boundary
    write_cell(0, 0, 0, 0);
    cast_ray(128, 128, 128, 200, 128, 128);
    write_cell(15, 15, 15, 0);
    cast_ray(3800, 3800, 3800, 4095, 4095, 4095);

    // Random: mostly casts through a sparsely filled grid, some writes and wide noise.
    for (int i = 0; i < 400; i++) begin
      calm = (i >= 150 && i < 220);
      n = $urandom_range(99);
      if (n < 25) write_cell($urandom_range(15), $urandom_range(15), $urandom_range(15),
                             $urandom_range(99) < 70);
      else if (n < 90) cast_ray(near_pos(), near_pos(), near_pos(),
                                near_pos(), near_pos(), near_pos());
      else cast_ray($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
                    $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)));
    end
    in_tvalid <= 0;

    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
